@@ hdl/krt_pkg.sv @@
// ----------------------------------------------------------------------------
// krt_pkg: shared types and codes for the keyed record table
// Request and response word layouts, opcodes, status codes and defaults.
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam int ENTRY_INDEX_W       = 10;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_MISSING = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] record_key;
      logic signed [31:0] quantity_in;
      logic [31:0]        price_in;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [31:0]       quantity_out;
      logic [31:0]              price_out;
      logic [ENTRY_INDEX_W-1:0] entry_index;
   } rsp_type;

endpackage

@@ hdl/krt_ram.sv @@
// ----------------------------------------------------------------------------
// krt_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module krt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = krt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/keyed_record_table_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_record_table_unit: append-only record table with linear key search
//
// Requests arrive on req_valid/req_ready with a req_data word (opcode, key,
// quantity, price); each request yields one rsp_data word on rsp_valid/
// rsp_ready. Add appends at the fill count, search returns the first entry
// with a matching key, update overwrites that entry's quantity.
// The block takes one request at a time: req_ready is high only while the
// sequencer is idle. Add and reserved opcodes go straight to the hold state,
// which loads the response word into the output register. Search and update
// scan the used entries one per cycle through the key RAM read port, up to
// the first matching key or the end of the used entries.
// The sequencer returns to idle as the response word is loaded, and only
// then is the next request taken.
// A finished response waits in the output register; while the receiver
// stalls, the next request may be accepted and worked on, and its result
// is held until the output register frees up.
// Reset clears the fill count and the sequencer; table contents are not
// cleared, since only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module keyed_record_table_unit #(
   parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  krt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output krt_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_HOLD = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pend_idx_ff, pend_idx_in;
   krt_pkg::req_type req_ff, req_in;
   krt_pkg::rsp_type res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   krt_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             add_we;
   logic             qty_we;
   logic [AW-1:0]    wr_addr;
   logic [31:0]      qty_wdata;
   logic [31:0]      key_rd, qty_rd, price_rd;

   function automatic logic [krt_pkg::ENTRY_INDEX_W-1:0] to_entry(input logic [AW-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[krt_pkg::ENTRY_INDEX_W-1:0];
   endfunction

   krt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (add_we),
      .wr_addr (wr_addr),
      .wr_data (req_data.record_key),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (key_rd)
   );

   krt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_qty_ram (
      .clock   (clock),
      .wr_en   (qty_we),
      .wr_addr (wr_addr),
      .wr_data (qty_wdata),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (qty_rd)
   );

   krt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_price_ram (
      .clock   (clock),
      .wr_en   (add_we),
      .wr_addr (wr_addr),
      .wr_data (req_data.price_in),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (price_rd)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      add_we       = 1'b0;
      qty_we       = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      qty_wdata    = req_data.quantity_in;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               scan_in = '0;
               pend_in = 1'b0;
               res_in  = '0;
               case (req_data.opcode)
                  krt_pkg::OP_ADD: begin
                     if (count_ff != FULL_COUNT) begin
                        add_we              = 1'b1;
                        qty_we              = 1'b1;
                        count_in            = count_ff + 1'b1;
                        res_in.status       = krt_pkg::STATUS_OK;
                        res_in.quantity_out = req_data.quantity_in;
                        res_in.price_out    = req_data.price_in;
                        res_in.entry_index  = to_entry(count_ff[AW-1:0]);
                     end else begin
                        res_in.status = krt_pkg::STATUS_FULL;
                     end
                     state_in = S_HOLD;
                  end
                  krt_pkg::OP_SEARCH, krt_pkg::OP_UPDATE: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     res_in.status = krt_pkg::STATUS_MISSING;
                     state_in      = S_HOLD;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // read data belongs to the address issued in the cycle before
            if (pend_ff && key_rd == req_ff.record_key) begin
               pend_in            = 1'b0;
               res_in.status      = krt_pkg::STATUS_OK;
               res_in.price_out   = price_rd;
               res_in.entry_index = to_entry(pend_idx_ff);
               if (req_ff.opcode == krt_pkg::OP_UPDATE) begin
                  qty_we              = 1'b1;
                  wr_addr             = pend_idx_ff;
                  qty_wdata           = req_ff.quantity_in;
                  res_in.quantity_out = req_ff.quantity_in;
               end else begin
                  res_in.quantity_out = qty_rd;
               end
               state_in = S_HOLD;
            end else if (scan_ff >= count_ff) begin
               pend_in       = 1'b0;
               res_in        = '0;
               res_in.status = krt_pkg::STATUS_MISSING;
               state_in      = S_HOLD;
            end else begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[AW-1:0];
               scan_in     = scan_ff + 1'b1;
            end
         end
         S_HOLD: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ hdl/krt_checker.sv @@
// ----------------------------------------------------------------------------
// krt_checker: port-level assertions for the keyed record table
// Watches the request and response channels; bound to keyed_record_table_unit.
// ----------------------------------------------------------------------------
module krt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input krt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input krt_pkg::rsp_type rsp_data
);

   // a pending response word holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word dropped or changed while stalled");

   // one request at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still in work");

   // failures carry all-zero payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != krt_pkg::STATUS_OK |->
         rsp_data.quantity_out == 0 && rsp_data.price_out == 0 &&
         rsp_data.entry_index == 0)
      else $error("failure response with nonzero fields");

   // a full status does not rise where a non-add response can first show
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.opcode != krt_pkg::OP_ADD |=>
         ##1 !(rsp_valid && rsp_data.status == krt_pkg::STATUS_FULL &&
               $rose(rsp_valid)))
      else $error("full status for a non-add request");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for keyed_record_table_unit
// Drives request words from a prebuilt queue, predicts each response from
// a local copy of the table, and checks every response word field by field.
// Stimulus covers an empty table, extreme field values, duplicate keys,
// misses, the reserved opcode, random mixed traffic, and long scans.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DEPTH         = krt_pkg::TABLE_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 550;
   localparam int STALL_LIMIT   = 8 * (DEPTH + 2) + 1000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int QUIET_START   = 4000;
   localparam int QUIET_END     = 14000;

   localparam logic [1:0] OP_RESERVED = 2'd3;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   krt_pkg::req_type req_data  = '0;
   logic             rsp_ready = 1'b0;
   logic             req_ready;
   logic             rsp_valid;
   krt_pkg::rsp_type rsp_data;

   krt_pkg::req_type pending_reqs [$];
   krt_pkg::rsp_type expected_rsps [$];
   krt_pkg::rsp_type want_rsp;

   // predicted table contents
   logic [31:0] table_keys   [DEPTH];
   logic [31:0] table_qtys   [DEPTH];
   logic [31:0] table_prices [DEPTH];
   int          table_fill = 0;

   // keys handed to the driver, in add order
   logic [31:0] issued_keys [DEPTH];
   int          issued_fill = 0;

   int error_count  = 0;
   int cycle_count  = 0;
   int stall_cycles = 0;

   keyed_record_table_unit #(.TABLE_DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic krt_pkg::rsp_type apply_request(input krt_pkg::req_type r);
      krt_pkg::rsp_type res;
      int               hit;
      res        = '0;
      res.status = krt_pkg::STATUS_MISSING;
      hit        = -1;
      case (r.opcode)
         krt_pkg::OP_ADD: begin
            if (table_fill >= DEPTH) begin
               res.status = krt_pkg::STATUS_FULL;
            end else begin
               table_keys[table_fill]   = r.record_key;
               table_qtys[table_fill]   = r.quantity_in;
               table_prices[table_fill] = r.price_in;
               res.status       = krt_pkg::STATUS_OK;
               res.quantity_out = r.quantity_in;
               res.price_out    = r.price_in;
               res.entry_index  = table_fill[krt_pkg::ENTRY_INDEX_W-1:0];
               table_fill++;
            end
         end
         krt_pkg::OP_SEARCH, krt_pkg::OP_UPDATE: begin
            // first match wins on duplicate keys
            for (int i = 0; i < table_fill; i++) begin
               if (hit < 0 && table_keys[i] == r.record_key) hit = i;
            end
            if (hit >= 0) begin
               if (r.opcode == krt_pkg::OP_UPDATE) table_qtys[hit] = r.quantity_in;
               res.status       = krt_pkg::STATUS_OK;
               res.quantity_out = table_qtys[hit];
               res.price_out    = table_prices[hit];
               res.entry_index  = hit[krt_pkg::ENTRY_INDEX_W-1:0];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic bit take_gap();
      if (cycle_count >= QUIET_START && cycle_count < QUIET_END) return 1'b0;
      return $urandom_range(99) < 24;
   endfunction

   task automatic queue_request(input logic [1:0] op, input logic [31:0] key,
                                input logic [31:0] qty, input logic [31:0] price);
      krt_pkg::req_type item;
      item.opcode      = op;
      item.record_key  = key;
      item.quantity_in = qty;
      item.price_in    = price;
      pending_reqs.push_back(item);
      if (op == krt_pkg::OP_ADD && issued_fill < DEPTH) begin
         issued_keys[issued_fill] = key;
         issued_fill++;
      end
   endtask

   function automatic logic [31:0] pick_key(input int reuse_pct);
      if (issued_fill > 0 && $urandom_range(99) < reuse_pct)
         return issued_keys[$urandom_range(issued_fill - 1)];
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(apply_request(req_data));
            void'(pending_reqs.pop_front());
         end
         // hold the word until it is taken
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && !take_gap()) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response word: status %0d", rsp_data.status);
               error_count++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               if (rsp_data.status !== want_rsp.status) begin
                  $error("status: expected %0d, actual %0d",
                         want_rsp.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.quantity_out !== want_rsp.quantity_out) begin
                  $error("quantity_out: expected %0d, actual %0d",
                         want_rsp.quantity_out, rsp_data.quantity_out);
                  error_count++;
               end
               if (rsp_data.price_out !== want_rsp.price_out) begin
                  $error("price_out: expected %0d, actual %0d",
                         want_rsp.price_out, rsp_data.price_out);
                  error_count++;
               end
               if (rsp_data.entry_index !== want_rsp.entry_index) begin
                  $error("entry_index: expected %0d, actual %0d",
                         want_rsp.entry_index, rsp_data.entry_index);
                  error_count++;
               end
            end
         end
         rsp_ready <= !take_gap();
      end
   end

   // watchdog: count cycles with no word moving on either channel
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int roll;

      // empty table: every lookup misses
      queue_request(krt_pkg::OP_SEARCH, 32'h0000_0000, 32'h1234_5678, 32'h9ABC_DEF0);
      queue_request(krt_pkg::OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      queue_request(OP_RESERVED,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // extreme keys, quantities and prices
      queue_request(krt_pkg::OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      queue_request(krt_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_request(krt_pkg::OP_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
      queue_request(krt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      // duplicate key: lookups must land on the lower entry
      queue_request(krt_pkg::OP_ADD,    32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_0007);
      queue_request(krt_pkg::OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      queue_request(krt_pkg::OP_UPDATE, 32'h7FFF_FFFF, 32'h0000_007B, 32'hFFFF_FFFF);
      queue_request(krt_pkg::OP_SEARCH, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      queue_request(krt_pkg::OP_SEARCH, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
      queue_request(krt_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      // misses on a populated table, then updates, adds and lookups that hit
      queue_request(krt_pkg::OP_SEARCH, 32'h0000_3039, 32'h0000_0000, 32'h0000_0000);
      queue_request(krt_pkg::OP_UPDATE, 32'h0000_3039, 32'h1111_1111, 32'h0000_0000);
      queue_request(OP_RESERVED,        32'h7FFF_FFFF, 32'h2222_2222, 32'h3333_3333);
      queue_request(krt_pkg::OP_UPDATE, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
      queue_request(krt_pkg::OP_SEARCH, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      queue_request(krt_pkg::OP_ADD,    32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      queue_request(krt_pkg::OP_ADD,    32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      queue_request(krt_pkg::OP_SEARCH, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0000_0000);

      // mixed traffic, lookups mostly aimed at stored keys
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(99);
         if (roll < 35)
            queue_request(krt_pkg::OP_ADD, pick_key(25), pick_value(), pick_value());
         else if (roll < 65)
            queue_request(krt_pkg::OP_SEARCH, pick_key(70), $urandom, $urandom);
         else if (roll < 90)
            queue_request(krt_pkg::OP_UPDATE, pick_key(70), pick_value(), $urandom);
         else
            queue_request(OP_RESERVED, pick_key(50), $urandom, $urandom);
      end

      // tail: lookups on the last stored key and on an absent key scan deep; the first stored key is looked up too
      queue_request(krt_pkg::OP_SEARCH, issued_keys[issued_fill-1], $urandom, $urandom);
      queue_request(krt_pkg::OP_UPDATE, issued_keys[issued_fill-1], 32'h8000_0000,
                    $urandom);
      queue_request(krt_pkg::OP_SEARCH, issued_keys[issued_fill-1], $urandom, $urandom);
      queue_request(krt_pkg::OP_SEARCH, issued_keys[0], $urandom, $urandom);
      queue_request(krt_pkg::OP_SEARCH, 32'h0BAD_F00D, $urandom, $urandom);
      queue_request(krt_pkg::OP_UPDATE, 32'h0BAD_F00D, $urandom, $urandom);
      queue_request(OP_RESERVED, issued_keys[0], $urandom, $urandom);
      queue_request(krt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      queue_request(krt_pkg::OP_SEARCH, 32'hFFFF_FFFF, $urandom, $urandom);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
